@@ design/bbfh_pkg.sv @@
// ----------------------------------------------------------------------------
// bbfh_pkg
// Shared types and constants for the bounded back/forward history block.
// ----------------------------------------------------------------------------
package bbfh_pkg;

    localparam int            LIMIT_W     = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_VISIT   = 2'd0,
        OP_BACK    = 2'd1,
        OP_FORWARD = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_SHIFT = 1'b1
    } t_state;

    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

endpackage

@@ design/bbfh_cell.sv @@
// ----------------------------------------------------------------------------
// bbfh_cell
// One history entry. Loads its upper neighbor on a shift, or the broadcast
// location on a write; a write during a shift wins.
// ----------------------------------------------------------------------------
module bbfh_cell
    import bbfh_pkg::*;
#(
    parameter int LOCATION_BITS = 32
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [LOCATION_BITS-1:0] i_wdata,
    input  logic [LOCATION_BITS-1:0] i_up,
    output logic [LOCATION_BITS-1:0] o_q
);

    logic [LOCATION_BITS-1:0] r_entry;
    logic [LOCATION_BITS-1:0] n_entry;

    always_comb begin
        priority if (i_ctl.wr) begin
            n_entry = i_wdata;
        end else if (i_ctl.shift) begin
            n_entry = i_up;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_q = r_entry;

endmodule

@@ design/bounded_back_forward_history.sv @@
// ----------------------------------------------------------------------------
// bounded_back_forward_history
// Bounded list of location identifiers with a cursor, held in a row of
// cells in order from the oldest entry; dropping old entries shifts the row.
//
//   channel   signals                                     direction
//   request   i_valid / o_ready, i_opcode, i_location_*   in
//   result    o_valid / i_ready, o_result_*, o_can_*,     out
//             o_stored_count
//   config    i_cfg_wr_en, i_cfg_wr_data (history limit)  in
//
// a request is registered on acceptance and executed once the output
// register is free, one request per cycle when the result side keeps up
// and no visit is shifting; a visit that must drop d > 1 oldest entries
// (only after the limit was lowered) shifts once with its write and d - 1
// more times in the shift state; results wait in an output register; the
// request register takes one more request while the result is stalled
// synchronous reset empties the list; the limit returns to 16
// ----------------------------------------------------------------------------
module bounded_back_forward_history
    import bbfh_pkg::*;
#(
    parameter int MAX_ENTRIES   = 16,
    parameter int LOCATION_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [LOCATION_BITS-1:0]         i_location_id,
    input  logic                             i_location_valid,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [LOCATION_BITS-1:0]         o_result_location,
    output logic                             o_result_valid,
    output logic                             o_can_go_back,
    output logic                             o_can_go_forward,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] o_stored_count,
    input  logic                             i_cfg_wr_en,
    input  logic [LIMIT_W-1:0]               i_cfg_wr_data
);

    localparam int PTR_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int WIDE_W = CNT_W + 1;

    logic [LIMIT_W-1:0]       r_limit;
    logic                     r_req_pend;
    t_opcode                  r_req_op;
    logic [LOCATION_BITS-1:0] r_req_loc;
    logic                     r_req_lv;
    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [PTR_W-1:0]         r_cursor;
    logic [PTR_W-1:0]         n_cursor;
    logic [WIDE_W-1:0]        r_left;
    logic [WIDE_W-1:0]        n_left;
    logic                     r_out_valid;
    logic [LOCATION_BITS-1:0] r_out_loc;
    logic                     r_out_rv;
    logic                     r_out_back;
    logic                     r_out_fwd;
    logic [CNT_W-1:0]         r_out_count;

    logic [CNT_W-1:0]         lim_eff;
    logic                     have;
    logic                     out_free;
    logic                     accept;
    logic                     emit;
    logic                     req_done;
    logic                     shift;
    logic                     wr_en;
    logic [WIDE_W-1:0]        wr_idx;
    logic [WIDE_W-1:0]        newcount;
    logic [PTR_W-1:0]         rd_addr;
    logic [LOCATION_BITS-1:0] rd_data;
    logic [LOCATION_BITS-1:0] res_loc;
    logic                     res_valid;
    logic                     back_ok;
    logic                     can_fwd;

    logic [LOCATION_BITS-1:0] cell_q [MAX_ENTRIES];
    t_cell_ctl                cell_ctl [MAX_ENTRIES];

    // cell row
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        logic [LOCATION_BITS-1:0] up;
        if (gi == MAX_ENTRIES - 1) begin : g_last
            assign up = '0;
        end else begin : g_mid
            assign up = cell_q[gi+1];
        end
        assign cell_ctl[gi].shift = shift;
        assign cell_ctl[gi].wr    = wr_en && (wr_idx == WIDE_W'(gi));
        bbfh_cell #(
            .LOCATION_BITS(LOCATION_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[gi]),
            .i_wdata(r_req_loc),
            .i_up   (up),
            .o_q    (cell_q[gi])
        );
    end

    always_comb begin
        if (r_limit == '0) begin
            lim_eff = CNT_W'(1);
        end else if (32'(r_limit) > MAX_ENTRIES) begin
            lim_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            lim_eff = CNT_W'(r_limit);
        end
    end

    always_comb begin
        unique case (r_req_op)
            OP_BACK:            rd_addr = r_cursor - PTR_W'(1);
            OP_FORWARD:         rd_addr = r_cursor + PTR_W'(1);
            OP_VISIT, OP_CLEAR: rd_addr = r_cursor;
        endcase
    end
    assign rd_data = cell_q[rd_addr];

    assign have     = (r_count != '0);
    assign out_free = !r_out_valid || i_ready;
    assign newcount = have ? (WIDE_W'(r_cursor) + WIDE_W'(2)) : WIDE_W'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_left    = r_left;
        shift     = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = '0;
        res_loc   = '0;
        res_valid = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (r_req_pend && out_free) begin
                    unique case (r_req_op)
                        OP_VISIT: begin
                            if (r_req_lv && !(have && rd_data == r_req_loc)) begin
                                wr_en = 1'b1;
                                if (newcount > WIDE_W'(lim_eff)) begin
                                    shift    = 1'b1;
                                    wr_idx   = newcount - WIDE_W'(2);
                                    n_count  = lim_eff;
                                    n_cursor = PTR_W'(lim_eff - CNT_W'(1));
                                    n_left   = newcount - WIDE_W'(lim_eff) - WIDE_W'(1);
                                    if (n_left != '0) begin
                                        n_state = ST_SHIFT;
                                    end
                                end else begin
                                    wr_idx   = newcount - WIDE_W'(1);
                                    n_count  = CNT_W'(newcount);
                                    n_cursor = PTR_W'(newcount - WIDE_W'(1));
                                end
                            end
                        end
                        OP_BACK: begin
                            if (have && r_cursor != '0) begin
                                n_cursor  = r_cursor - PTR_W'(1);
                                res_loc   = rd_data;
                                res_valid = 1'b1;
                            end
                        end
                        OP_FORWARD: begin
                            if (have && (WIDE_W'(r_cursor) + WIDE_W'(1) < WIDE_W'(r_count))) begin
                                n_cursor  = r_cursor + PTR_W'(1);
                                res_loc   = rd_data;
                                res_valid = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                    endcase
                    emit = (n_state == ST_RUN);
                end
            end
            ST_SHIFT: begin
                if (r_left != '0) begin
                    shift  = 1'b1;
                    n_left = r_left - WIDE_W'(1);
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_RUN;
                end
            end
        endcase
    end

    assign req_done = emit;
    assign o_ready  = !r_req_pend || req_done;
    assign accept   = i_valid && o_ready;
    assign back_ok  = (n_count != '0) && (n_cursor != '0);
    assign can_fwd  = (n_count != '0) &&
                      (WIDE_W'(n_cursor) + WIDE_W'(1) < WIDE_W'(n_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_req_pend  <= 1'b0;
            r_req_op    <= OP_VISIT;
            r_state     <= ST_RUN;
            r_count     <= '0;
            r_cursor    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (accept) begin
                r_req_pend <= 1'b1;
                r_req_op   <= t_opcode'(i_opcode);
            end else if (req_done) begin
                r_req_pend <= 1'b0;
            end
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_left   <= n_left;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_loc <= i_location_id;
            r_req_lv  <= i_location_valid;
        end
        if (emit) begin
            r_out_loc   <= res_loc;
            r_out_rv    <= res_valid;
            r_out_back  <= back_ok;
            r_out_fwd   <= can_fwd;
            r_out_count <= n_count;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_location = r_out_loc;
    assign o_result_valid    = r_out_rv;
    assign o_can_go_back     = r_out_back;
    assign o_can_go_forward  = r_out_fwd;
    assign o_stored_count    = r_out_count;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (WIDE_W'(r_cursor) < WIDE_W'(r_count)))
        else $error("cursor beyond stored entries");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_ENTRIES)
        else $error("entry count above capacity");

    a_shift_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> r_req_pend)
        else $error("shift pass without a pending request");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_ready))
        else $error("result written over a waiting result");

endmodule

@@ bench/tb_bounded_back_forward_history.sv @@
// ----------------------------------------------------------------------------
// tb_bounded_back_forward_history
// Self-checking bench for the bounded back/forward history block. A
// scoreboard keeps its own copy of the history list, cursor and limit,
// predicts one result per accepted request and checks the result stream in
// order. A directed opening covers empty-list moves, ignored visits and
// truncation. Random phases follow under several limits and idle patterns,
// including a long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_bounded_back_forward_history;
    import bbfh_pkg::*;

    localparam int DEPTH         = 16;
    localparam int PHASES        = 7;
    localparam int RANDOM_ITEMS  = 170;
    localparam int FILL_ITEMS    = 18;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRESSURE_PHASE = 4;

    typedef struct packed {
        logic [31:0] location;
        logic        moved;
        logic        back_ok;
        logic        forward_ok;
        logic [4:0]  count;
    } t_history_result;

    class history_scoreboard;
        logic [31:0]     entries [DEPTH];
        int unsigned     oldest;
        int unsigned     count;
        int unsigned     cursor;
        int unsigned     limit;
        t_history_result pending [$];
        int unsigned     failures;

        function new();
            oldest   = 0;
            count    = 0;
            cursor   = 0;
            limit    = LIMIT_RESET;
            failures = 0;
        endfunction

        function void note_request(t_opcode op, logic [31:0] loc, logic loc_ok);
            t_history_result want;
            int unsigned     lim;
            int unsigned     fill;
            want = '0;
            lim  = (limit == 0) ? 1 : ((limit > DEPTH) ? DEPTH : limit);
            case (op)
                OP_VISIT: begin
                    if (loc_ok && !(count > 0 && entries[(oldest + cursor) % DEPTH] == loc)) begin
                        fill = (count > 0) ? cursor + 2 : 1;
                        entries[(oldest + fill - 1) % DEPTH] = loc;
                        if (fill > lim) begin
                            oldest = (oldest + fill - lim) % DEPTH;
                            fill   = lim;
                        end
                        count  = fill;
                        cursor = fill - 1;
                    end
                end
                OP_BACK: begin
                    if (count > 0 && cursor > 0) begin
                        cursor--;
                        want.location = entries[(oldest + cursor) % DEPTH];
                        want.moved    = 1'b1;
                    end
                end
                OP_FORWARD: begin
                    if (count > 0 && cursor + 1 < count) begin
                        cursor++;
                        want.location = entries[(oldest + cursor) % DEPTH];
                        want.moved    = 1'b1;
                    end
                end
                default: begin
                    count  = 0;
                    cursor = 0;
                    oldest = 0;
                end
            endcase
            want.back_ok    = (count > 0 && cursor > 0);
            want.forward_ok = (count > 0 && cursor + 1 < count);
            want.count      = count[4:0];
            pending = {pending, want};
        endfunction

        function void check_result(t_history_result got);
            t_history_result want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: loc=%h moved=%b back=%b fwd=%b cnt=%0d",
                             got.location, got.moved, got.back_ok, got.forward_ok, got.count);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display({"mismatch: expected loc=%h moved=%b back=%b fwd=%b cnt=%0d,",
                                  " got loc=%h moved=%b back=%b fwd=%b cnt=%0d"},
                                 want.location, want.moved, want.back_ok, want.forward_ok,
                                 want.count, got.location, got.moved, got.back_ok,
                                 got.forward_ok, got.count);
                end
            end
        endfunction
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic               o_ready;
    logic [1:0]         i_opcode         = OP_VISIT;
    logic [31:0]        i_location_id    = '0;
    logic               i_location_valid = 1'b0;
    logic               o_valid;
    logic               i_ready          = 1'b0;
    logic [31:0]        o_result_location;
    logic               o_result_valid;
    logic               o_can_go_back;
    logic               o_can_go_forward;
    logic [4:0]         o_stored_count;
    logic               i_cfg_wr_en      = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wr_data    = '0;

    history_scoreboard  sb;
    int unsigned        idle_pct     = 0;
    int unsigned        stall_pct    = 0;
    int unsigned        hold_req     = 0;
    int unsigned        hold_ack     = 0;
    int unsigned        hold_left    = 0;
    int unsigned        cycle_count  = 0;

    int unsigned phase_idle  [PHASES] = '{0, 75, 0, 13, 0, 0, 75};
    int unsigned phase_stall [PHASES] = '{0, 0, 75, 13, 0, 75, 0};
    int unsigned phase_limit [PHASES] = '{31, 5, 0, 16, 3, 0, 1};

    bounded_back_forward_history dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_location_id     (i_location_id),
        .i_location_valid  (i_location_valid),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_result_location (o_result_location),
        .o_result_valid    (o_result_valid),
        .o_can_go_back     (o_can_go_back),
        .o_can_go_forward  (o_can_go_forward),
        .o_stored_count    (o_stored_count),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            i_ready   <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_result_location, o_result_valid, o_can_go_back,
                             o_can_go_forward, o_stored_count});
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(input t_opcode op, input logic [31:0] loc, input logic loc_ok);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_opcode         <= op;
        i_location_id    <= loc;
        i_location_valid <= loc_ok;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_request(op, loc, loc_ok);
    endtask

    // mostly visits and moves; small location values make repeated visits common
    task automatic send_random_request();
        int unsigned roll;
        logic [31:0] loc;
        roll = $urandom_range(99);
        loc  = ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : $urandom;
        if (roll < 50)
            send_request(OP_VISIT, loc, $urandom_range(9) != 0);
        else if (roll < 72)
            send_request(OP_BACK, loc, 1'($urandom_range(1)));
        else if (roll < 97)
            send_request(OP_FORWARD, loc, 1'($urandom_range(1)));
        else
            send_request(OP_CLEAR, loc, 1'($urandom_range(1)));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.limit = value;
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening at the reset limit
        send_request(OP_BACK, 32'h0, 1'b1);
        send_request(OP_FORWARD, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_VISIT, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_VISIT, 32'h0000_0000, 1'b1);
        send_request(OP_VISIT, 32'h0000_0000, 1'b1);
        send_request(OP_VISIT, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_VISIT, 32'h5A5A_A5A5, 1'b1);
        send_request(OP_BACK, 32'h0, 1'b0);
        send_request(OP_BACK, 32'h0, 1'b0);
        send_request(OP_BACK, 32'h0, 1'b0);
        send_request(OP_VISIT, 32'h1234_5678, 1'b1);
        send_request(OP_FORWARD, 32'h0, 1'b0);
        send_request(OP_BACK, 32'h0, 1'b0);
        send_request(OP_FORWARD, 32'h0, 1'b0);
        send_request(OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_FORWARD, 32'h0, 1'b0);
        drain_results();

        // small limit: oldest entry dropped, repeat visit keeps forward entry
        write_limit(5'd2);
        send_request(OP_VISIT, 32'hA000_000A, 1'b1);
        send_request(OP_VISIT, 32'hB000_000B, 1'b1);
        send_request(OP_VISIT, 32'hC000_000C, 1'b1);
        send_request(OP_BACK, 32'h0, 1'b0);
        send_request(OP_BACK, 32'h0, 1'b0);
        send_request(OP_VISIT, 32'hB000_000B, 1'b1);
        send_request(OP_FORWARD, 32'h0, 1'b0);
        send_request(OP_CLEAR, 32'h0, 1'b0);

        // each phase ends with a fill so that a lower limit in the next phase drops several entries
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_limit((p == 5) ? LIMIT_W'($urandom_range(31)) : LIMIT_W'(phase_limit[p]));
            idle_pct   = phase_idle[p];
            stall_pct <= phase_stall[p];
            if (p == PRESSURE_PHASE)
                hold_req <= hold_req + 1;
            repeat (RANDOM_ITEMS) send_random_request();
            repeat (FILL_ITEMS) send_request(OP_VISIT, $urandom, 1'b1);
        end

        drain_results();
        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/bbfh_pkg.sv
design/bbfh_cell.sv
design/bounded_back_forward_history.sv
bench/tb_bounded_back_forward_history.sv
